// ===== rtl/sida_pkg.sv =====
// shared types and constants for the signed integer to decimal text converter
`timescale 1ns / 1ps
package sida_pkg;

   localparam int unsigned DIGIT_BITS = 4;
   localparam int unsigned CHAR_BITS  = 7;

   localparam logic [CHAR_BITS-1:0] CHR_ZERO  = 7'd48;
   localparam logic [CHAR_BITS-1:0] CHR_MINUS = 7'd45;

   localparam logic [DIGIT_BITS-1:0] DIGIT_ADJ_LIMIT = 4'd5;
   localparam logic [DIGIT_BITS-1:0] DIGIT_ADJ       = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_DIGITS
   } state_type;

endpackage

// ===== rtl/sida_dabble_step.sv =====
// one shift-and-add-3 step of the binary to bcd conversion
`timescale 1ns / 1ps
module sida_dabble_step #(
   parameter int unsigned NUM_DIGITS = 10
) (
   input  logic [NUM_DIGITS*sida_pkg::DIGIT_BITS-1:0] bcd_cur,
   input  logic                                       bit_in,
   output logic [NUM_DIGITS*sida_pkg::DIGIT_BITS-1:0] bcd_nxt
);

   localparam int unsigned DB = sida_pkg::DIGIT_BITS;

   logic [NUM_DIGITS*DB-1:0] adjusted;

   // add 3 to every digit of 5 or more, then shift one bit in
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_cur[i*DB +: DB] >= sida_pkg::DIGIT_ADJ_LIMIT) begin
            adjusted[i*DB +: DB] = bcd_cur[i*DB +: DB] + sida_pkg::DIGIT_ADJ;
         end else begin
            adjusted[i*DB +: DB] = bcd_cur[i*DB +: DB];
         end
      end
      bcd_nxt = {adjusted[NUM_DIGITS*DB-2:0], bit_in};
   end

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// sequence: load the request, run VALUE_WIDTH conversion steps, drop leading zeros one at a
//   time, then emit the optional minus sign and the digits, one character per accepted transfer
// one item at a time: req_ready is high only in idle, so a new value waits for the last character;
//   the single shared shift-and-add-3 step is reused for every conversion step
// reset: synchronous active-high reset returns the sequencer to idle, no result pending
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [VALUE_WIDTH-1:0]      req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sida_pkg::CHAR_BITS-1:0]     rsp_char_code,
   output logic                               rsp_last_char
);

   localparam int unsigned DB = sida_pkg::DIGIT_BITS;
   // decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
   localparam int unsigned NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int unsigned BCD_BITS   = NUM_DIGITS * DB;
   localparam int unsigned STEP_BITS  = $clog2(VALUE_WIDTH + 1);
   localparam int unsigned LEFT_BITS  = $clog2(NUM_DIGITS + 1);

   sida_pkg::state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;       // magnitude, shifted out msb first
   logic [BCD_BITS-1:0]    bcd_ff, bcd_in;       // decimal digits, top digit emitted
   logic [STEP_BITS-1:0]   step_ff, step_in;     // conversion steps still to run
   logic [LEFT_BITS-1:0]   left_ff, left_in;     // digits still to skip or emit
   logic                   neg_ff, neg_in;

   logic [BCD_BITS-1:0]    bcd_step;
   logic [DB-1:0]          top_digit;
   logic                   req_fire;
   logic                   rsp_fire;
   logic [VALUE_WIDTH-1:0] magnitude;

   assign top_digit = bcd_ff[BCD_BITS-1 -: DB];
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // unsigned magnitude; the most negative value maps onto 2^(VALUE_WIDTH-1) exactly
   assign magnitude = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;

   // shared conversion unit, one bit of the magnitude per cycle
   sida_dabble_step #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_step (
      .bcd_cur (bcd_ff),
      .bit_in  (bin_ff[VALUE_WIDTH-1]),
      .bcd_nxt (bcd_step)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sida_pkg::ST_IDLE: begin
            if (req_fire) state_in = sida_pkg::ST_CONVERT;
         end
         sida_pkg::ST_CONVERT: begin
            if (step_ff == STEP_BITS'(1)) state_in = sida_pkg::ST_SKIP;
         end
         sida_pkg::ST_SKIP: begin
            // leading zeros are dropped, but the last digit always stays
            if (!(top_digit == '0 && left_ff != LEFT_BITS'(1))) begin
               state_in = neg_ff ? sida_pkg::ST_SIGN : sida_pkg::ST_DIGITS;
            end
         end
         sida_pkg::ST_SIGN: begin
            if (rsp_fire) state_in = sida_pkg::ST_DIGITS;
         end
         sida_pkg::ST_DIGITS: begin
            if (rsp_fire && left_ff == LEFT_BITS'(1)) state_in = sida_pkg::ST_IDLE;
         end
         default: state_in = sida_pkg::ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      left_in = left_ff;
      neg_in  = neg_ff;
      unique case (state_ff)
         sida_pkg::ST_IDLE: begin
            if (req_fire) begin
               bin_in  = magnitude;
               bcd_in  = '0;
               step_in = STEP_BITS'(VALUE_WIDTH);
               left_in = LEFT_BITS'(NUM_DIGITS);
               neg_in  = req_value[VALUE_WIDTH-1];
            end
         end
         sida_pkg::ST_CONVERT: begin
            bcd_in  = bcd_step;
            bin_in  = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
            step_in = step_ff - 1'b1;
         end
         sida_pkg::ST_SKIP: begin
            if (top_digit == '0 && left_ff != LEFT_BITS'(1)) begin
               bcd_in  = {bcd_ff[BCD_BITS-DB-1:0], {DB{1'b0}}};
               left_in = left_ff - 1'b1;
            end
         end
         sida_pkg::ST_SIGN: begin
         end
         sida_pkg::ST_DIGITS: begin
            if (rsp_fire && left_ff != LEFT_BITS'(1)) begin
               bcd_in  = {bcd_ff[BCD_BITS-DB-1:0], {DB{1'b0}}};
               left_in = left_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // outputs, decoded from the registers only, with no path from the inputs
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      rsp_char_code = sida_pkg::CHR_ZERO;
      rsp_last_char = 1'b0;
      unique case (state_ff)
         sida_pkg::ST_IDLE: req_ready = 1'b1;
         sida_pkg::ST_CONVERT: begin
         end
         sida_pkg::ST_SKIP: begin
         end
         sida_pkg::ST_SIGN: begin
            rsp_valid     = 1'b1;
            rsp_char_code = sida_pkg::CHR_MINUS;
         end
         sida_pkg::ST_DIGITS: begin
            rsp_valid     = 1'b1;
            rsp_char_code = sida_pkg::CHR_ZERO
                          + {{(sida_pkg::CHAR_BITS-DB){1'b0}}, top_digit};
            rsp_last_char = (left_ff == LEFT_BITS'(1));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sida_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      left_ff <= left_in;
      neg_ff  <= neg_in;
   end

endmodule
